/* src/bezp_pkg.sv */
// Shared constants for the cubic Bezier point evaluator.
// No dependencies.
package bezp_pkg;

	localparam int NUM_POINTS   = 4;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_P0_X = 3'd0;
	localparam cfg_idx_t REG_P0_Y = 3'd1;
	localparam cfg_idx_t REG_P1_X = 3'd2;
	localparam cfg_idx_t REG_P1_Y = 3'd3;
	localparam cfg_idx_t REG_P2_X = 3'd4;
	localparam cfg_idx_t REG_P2_Y = 3'd5;
	localparam cfg_idx_t REG_P3_X = 3'd6;
	localparam cfg_idx_t REG_P3_Y = 3'd7;

	// stall control shared by the cell rows
	typedef struct packed {
		logic en;
		logic in_xfer;
	} pipe_ctrl_t;

endpackage

/* src/bezp_if.sv */
// Valid/ready channel interfaces for curve parameter and curve point.
// No dependencies.
interface bezp_param_if #(
	parameter int PARAM_FRAC_BITS = 16
);
	logic                     valid;
	logic                     ready;
	logic [PARAM_FRAC_BITS:0] curve_param;

	modport source (output valid, output curve_param, input ready);
	modport sink   (input valid, input curve_param, output ready);
endinterface

interface bezp_point_if #(
	parameter int OUT_BITS = 14
);
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] curve_x;
	logic [OUT_BITS-1:0] curve_y;

	modport source (output valid, output curve_x, output curve_y, input ready);
	modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

/* src/bezp_cfg_regs.sv */
// Control point register file, written through the plain write port.
// Depends on bezp_pkg.
module bezp_cfg_regs import bezp_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  cfg_idx_t                              cfg_index,
	input  logic [COORD_BITS-1:0]                 cfg_data,
	output logic [NUM_POINTS-1:0][COORD_BITS-1:0] pt_x,
	output logic [NUM_POINTS-1:0][COORD_BITS-1:0] pt_y
);

	logic [NUM_POINTS-1:0][COORD_BITS-1:0] pt_x_q;
	logic [NUM_POINTS-1:0][COORD_BITS-1:0] pt_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_x_q <= '0;
			pt_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_P0_X: pt_x_q[0] <= cfg_data;
				REG_P0_Y: pt_y_q[0] <= cfg_data;
				REG_P1_X: pt_x_q[1] <= cfg_data;
				REG_P1_Y: pt_y_q[1] <= cfg_data;
				REG_P2_X: pt_x_q[2] <= cfg_data;
				REG_P2_Y: pt_y_q[2] <= cfg_data;
				REG_P3_X: pt_x_q[3] <= cfg_data;
				REG_P3_Y: pt_y_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pt_x = pt_x_q;
	assign pt_y = pt_y_q;

endmodule

/* src/bezp_lerp_cell.sv */
// One registered fixed-point lerp: a + round(t * (b - a)), t in Q1.P.
// Depends on bezp_pkg.
module bezp_lerp_cell import bezp_pkg::*; #(
	parameter int W = 14,
	parameter int P = 16
) (
	input  logic         clk,
	input  pipe_ctrl_t   ctrl,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [P:0]   t,
	output logic [W-1:0] q
);

	localparam int PW = P + W + 3;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (P - 1);

	logic signed [W:0]    diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;
	logic signed [PW-1:0] shifted;
	logic        [W+1:0]  sum;
	logic        [W-1:0]  res_q;

	always_comb begin
		diff    = $signed({1'b0, b}) - $signed({1'b0, a});
		prod    = PW'($signed({1'b0, t}) * diff);
		rnd     = prod + HALF;
		shifted = rnd >>> P;
		sum     = {2'b00, a} + shifted[W+1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			res_q <= sum[W-1:0];
		end
	end

	assign q = res_q;

endmodule

/* src/cubic_bezier_point_eval.sv */
// Cubic Bezier point evaluator, de Casteljau scheme as three rows of lerp cells.
// Depends on bezp_pkg, bezp_if, bezp_cfg_regs, bezp_lerp_cell.
//
//   channel  | dir | handshake      | payload
//   sample   | in  | valid / ready  | curve_param (t, Q1.PARAM_FRAC_BITS)
//   point    | out | valid / ready  | curve_x, curve_y (Q.COORD.OUT_FRAC)
//   cfg      | in  | cfg_we         | cfg_index, cfg_data
//
// One point per cycle while the output is not stalled; each lerp row is registered (one multiply each).
// The third row is the output register; the whole row chain advances together.
// A stalled output freezes all rows; sample.ready follows ~point.valid | point.ready.
// arst_n clears the stage valid bits and the control points.
module cubic_bezier_point_eval import bezp_pkg::*; #(
	parameter int COORD_BITS      = 10,
	parameter int PARAM_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	bezp_param_if.sink            sample,
	bezp_point_if.source          point
);

	localparam int W = COORD_BITS + OUT_FRAC_BITS;
	localparam int P = PARAM_FRAC_BITS;
	localparam logic [P:0] T_ONE = (P + 1)'(1) << P;

	logic [NUM_POINTS-1:0][COORD_BITS-1:0] pt_x;
	logic [NUM_POINTS-1:0][COORD_BITS-1:0] pt_y;
	logic [NUM_POINTS-1:0][W-1:0]          cx;
	logic [NUM_POINTS-1:0][W-1:0]          cy;

	logic [2:0][W-1:0] ax_s1, ay_s1;
	logic [1:0][W-1:0] bx_s2, by_s2;
	logic      [W-1:0] x_s3, y_s3;

	logic [P:0] t_sat;
	logic [P:0] t_s1, t_s2;
	logic       v_s1, v_s2, v_s3;
	pipe_ctrl_t ctrl;

	bezp_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pt_x      (pt_x),
		.pt_y      (pt_y)
	);

	always_comb begin
		for (int i = 0; i < NUM_POINTS; i++) begin
			cx[i] = W'(pt_x[i]) << OUT_FRAC_BITS;
			cy[i] = W'(pt_y[i]) << OUT_FRAC_BITS;
		end
		t_sat        = (sample.curve_param > T_ONE) ? T_ONE : sample.curve_param;
		ctrl.en      = !v_s3 || point.ready;
		ctrl.in_xfer = sample.valid && ctrl.en;
	end

	assign sample.ready = ctrl.en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctrl.en) begin
			v_s1 <= ctrl.in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			t_s1 <= t_sat;
			t_s2 <= t_s1;
		end
	end

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_row1
			bezp_lerp_cell #(.W(W), .P(P)) u_x (
				.clk(clk), .ctrl(ctrl), .a(cx[g]), .b(cx[g+1]), .t(t_sat), .q(ax_s1[g])
			);
			bezp_lerp_cell #(.W(W), .P(P)) u_y (
				.clk(clk), .ctrl(ctrl), .a(cy[g]), .b(cy[g+1]), .t(t_sat), .q(ay_s1[g])
			);
		end
		for (g = 0; g < 2; g++) begin : g_row2
			bezp_lerp_cell #(.W(W), .P(P)) u_x (
				.clk(clk), .ctrl(ctrl), .a(ax_s1[g]), .b(ax_s1[g+1]), .t(t_s1),
				.q(bx_s2[g])
			);
			bezp_lerp_cell #(.W(W), .P(P)) u_y (
				.clk(clk), .ctrl(ctrl), .a(ay_s1[g]), .b(ay_s1[g+1]), .t(t_s1),
				.q(by_s2[g])
			);
		end
	endgenerate

	bezp_lerp_cell #(.W(W), .P(P)) u_row3_x (
		.clk(clk), .ctrl(ctrl), .a(bx_s2[0]), .b(bx_s2[1]), .t(t_s2), .q(x_s3)
	);
	bezp_lerp_cell #(.W(W), .P(P)) u_row3_y (
		.clk(clk), .ctrl(ctrl), .a(by_s2[0]), .b(by_s2[1]), .t(t_s2), .q(y_s3)
	);

	assign point.valid   = v_s3;
	assign point.curve_x = x_s3;
	assign point.curve_y = y_s3;

endmodule

/* src/bezp_checker.sv */
// Port-level checks for cubic_bezier_point_eval, attached by bind.
// Depends on cubic_bezier_point_eval.
module bezp_checker #(
	parameter int OUT_BITS = 14
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [OUT_BITS-1:0] out_x
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x))
		else $error("stalled output changed");

endmodule

bind cubic_bezier_point_eval bezp_checker #(
	.OUT_BITS(COORD_BITS + OUT_FRAC_BITS)
) u_bezp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (point.valid),
	.out_ready (point.ready),
	.out_x     (point.curve_x)
);

/* dv/tb_cubic_bezier_point_eval.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cubic_bezier_point_eval: directed table, then random t sweeps.
// Depends on bezp_pkg, bezp_if and the DUT sources; predictor and checker live here.
module tb_cubic_bezier_point_eval;
	import bezp_pkg::*;

	localparam int COORD_W   = 10;
	localparam int FRAC_W    = 16;
	localparam int OUT_W     = 14;
	localparam int PIPE_LAT  = 3;
	localparam int PHASES    = 6;
	localparam int PHASE_LEN = 200;
	localparam int LONG_HOLD = 300;
	localparam int MAX_SHOWN = 10;
	localparam logic [FRAC_W:0] T_ONE = 17'd65536;

	typedef struct packed {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
	} curve_pt_t;

	typedef enum logic { ROW_T, ROW_CFG } row_kind_t;

	// ROW_CFG: arg[9:0] goes to register idx; ROW_T: arg is t, want used when chk
	typedef struct {
		row_kind_t        kind;
		cfg_idx_t         idx;
		logic [FRAC_W:0]  arg;
		bit               chk;
		logic [OUT_W-1:0] want_x;
		logic [OUT_W-1:0] want_y;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [COORD_W-1:0] cfg_data;

	bezp_param_if #(.PARAM_FRAC_BITS(FRAC_W)) sample_ch ();
	bezp_point_if #(.OUT_BITS(OUT_W))         point_ch ();

	cubic_bezier_point_eval #(
		.COORD_BITS      (COORD_W),
		.PARAM_FRAC_BITS (FRAC_W),
		.OUT_FRAC_BITS   (4)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.point     (point_ch)
	);

	logic [COORD_W-1:0] ctrl_pt [8];
	curve_pt_t          pending_pts [$];
	int unsigned        n_mismatch;
	int unsigned        n_points;
	int unsigned        n_params;
	int unsigned        n_settings;
	bit                 send_gap_en;
	bit                 rcv_stall_en;
	bit                 long_hold_req;

	dir_row_t dir_tab [$] = '{
		'{ROW_T,   REG_P0_X, 17'd0,      1'b1, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd65536,  1'b1, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd131071, 1'b1, 14'd0,     14'd0},
		'{ROW_CFG, REG_P0_X, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P0_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P1_X, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P1_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P2_X, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P2_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P3_X, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P3_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd0,      1'b1, 14'd16368, 14'd16368},
		'{ROW_T,   REG_P0_X, 17'd32768,  1'b1, 14'd16368, 14'd16368},
		'{ROW_T,   REG_P0_X, 17'd131071, 1'b1, 14'd16368, 14'd16368},
		'{ROW_CFG, REG_P0_X, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P0_Y, 17'd0,      1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P1_X, 17'd0,      1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P1_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P2_X, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P2_Y, 17'd0,      1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P3_X, 17'd0,      1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P3_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd0,      1'b1, 14'd16368, 14'd0},
		'{ROW_T,   REG_P0_X, 17'd65536,  1'b1, 14'd0,     14'd16368},
		'{ROW_T,   REG_P0_X, 17'd65537,  1'b1, 14'd0,     14'd16368},
		'{ROW_T,   REG_P0_X, 17'd98304,  1'b1, 14'd0,     14'd16368},
		'{ROW_T,   REG_P0_X, 17'd1,      1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd65535,  1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd32768,  1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd16384,  1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd49152,  1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P0_X, 17'd5,      1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P0_Y, 17'd900,    1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P1_X, 17'd1000,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P1_Y, 17'd17,     1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P2_X, 17'd300,    1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P2_Y, 17'd1023,   1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P3_X, 17'd0,      1'b0, 14'd0,     14'd0},
		'{ROW_CFG, REG_P3_Y, 17'd512,    1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd0,      1'b1, 14'd80,    14'd14400},
		'{ROW_T,   REG_P0_X, 17'd65536,  1'b1, 14'd0,     14'd8192},
		'{ROW_T,   REG_P0_X, 17'd12345,  1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd43210,  1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd100,    1'b0, 14'd0,     14'd0},
		'{ROW_T,   REG_P0_X, 17'd65000,  1'b0, 14'd0,     14'd0}
	};

	always #5 clk = ~clk;

	// one rounded fixed-point lerp step
	function automatic logic [OUT_W-1:0] lerp_q(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b,
			logic [FRAC_W:0] t);
		logic [40:0] acc;
		acc = (41'(T_ONE) - 41'(t)) * 41'(a) + 41'(t) * 41'(b) + 41'd32768;
		return OUT_W'(acc >> FRAC_W);
	endfunction

	function automatic logic [OUT_W-1:0] curve_axis(logic [COORD_W-1:0] c0,
			logic [COORD_W-1:0] c1, logic [COORD_W-1:0] c2, logic [COORD_W-1:0] c3,
			logic [FRAC_W:0] t);
		logic [OUT_W-1:0] a0, a1, a2, b0, b1;
		a0 = lerp_q({c0, 4'b0}, {c1, 4'b0}, t);
		a1 = lerp_q({c1, 4'b0}, {c2, 4'b0}, t);
		a2 = lerp_q({c2, 4'b0}, {c3, 4'b0}, t);
		b0 = lerp_q(a0, a1, t);
		b1 = lerp_q(a1, a2, t);
		return lerp_q(b0, b1, t);
	endfunction

	function automatic curve_pt_t predict_point(logic [FRAC_W:0] raw_t);
		logic [FRAC_W:0] t;
		curve_pt_t       p;
		t = (raw_t > T_ONE) ? T_ONE : raw_t;
		p.x = curve_axis(ctrl_pt[REG_P0_X], ctrl_pt[REG_P1_X], ctrl_pt[REG_P2_X],
			ctrl_pt[REG_P3_X], t);
		p.y = curve_axis(ctrl_pt[REG_P0_Y], ctrl_pt[REG_P1_Y], ctrl_pt[REG_P2_Y],
			ctrl_pt[REG_P3_Y], t);
		return p;
	endfunction

	// entered and left at a falling edge
	task automatic push_param(logic [FRAC_W:0] t, curve_pt_t want);
		sample_ch.valid       <= 1'b1;
		sample_ch.curve_param <= t;
		do @(posedge clk); while (!sample_ch.ready);
		pending_pts = {pending_pts, want};
		n_params++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		if (send_gap_en && $urandom_range(0, 5) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic drain_pipe();
		sample_ch.valid <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		ctrl_pt[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// point checker
	always @(posedge clk) begin
		curve_pt_t want;
		if (arst_n && point_ch.valid && point_ch.ready) begin
			n_points++;
			if (pending_pts.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_SHOWN)
					$display("%0t: unexpected point x=%0d y=%0d", $time,
						point_ch.curve_x, point_ch.curve_y);
			end else begin
				want = pending_pts.pop_front();
				if (point_ch.curve_x !== want.x || point_ch.curve_y !== want.y) begin
					n_mismatch++;
					if (n_mismatch <= MAX_SHOWN)
						$display("%0t: point mismatch exp x=%0d y=%0d got x=%0d y=%0d",
							$time, want.x, want.y, point_ch.curve_x, point_ch.curve_y);
				end
			end
		end
	end

	// output side back-pressure
	initial begin
		point_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				point_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				point_ch.ready <= 1'b1;
			end else if (rcv_stall_en && $urandom_range(0, 7) == 0) begin
				point_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				point_ch.ready <= 1'b1;
			end else begin
				point_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [FRAC_W:0]    t;
		logic [COORD_W-1:0] val;
		curve_pt_t          want;
		bit                 cfg_idle;
		int unsigned        sel;

		clk                   = 1'b0;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_P0_X;
		cfg_data              = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.curve_param = '0;
		n_mismatch            = 0;
		n_points              = 0;
		n_params              = 0;
		n_settings            = 1;
		send_gap_en           = 1'b1;
		rcv_stall_en          = 1'b1;
		long_hold_req         = 1'b0;
		cfg_idle              = 1'b1;
		foreach (ctrl_pt[i]) ctrl_pt[i] = '0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				if (!cfg_idle) begin
					drain_pipe();
					n_settings++;
				end
				cfg_idle = 1'b1;
				write_reg(dir_tab[i].idx, dir_tab[i].arg[COORD_W-1:0]);
			end else begin
				cfg_idle = 1'b0;
				idle_gap();
				if (dir_tab[i].chk)
					want = '{x: dir_tab[i].want_x, y: dir_tab[i].want_y};
				else
					want = predict_point(dir_tab[i].arg);
				push_param(dir_tab[i].arg, want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_pipe();
			n_settings++;
			if (ph == PHASES - 1) begin
				send_gap_en  = 1'b0;
				rcv_stall_en = 1'b0;
			end
			for (int r = 0; r < 8; r++) begin
				case (ph)
					1:       val = '0;
					3:       val = '1;
					4:       val = $urandom_range(0, 1) ? '1 : '0;
					default: val = COORD_W'($urandom_range(0, 1023));
				endcase
				write_reg(cfg_idx_t'(r), val);
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 2 && n == 10)
					long_hold_req = 1'b1;
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					t = (FRAC_W + 1)'($urandom_range(0, 65536));
				end else if (sel == 7) begin
					case ($urandom_range(0, 4))
						0:       t = 17'd0;
						1:       t = 17'd1;
						2:       t = 17'd65535;
						3:       t = 17'd65536;
						default: t = 17'd65537;
					endcase
				end else begin
					t = (FRAC_W + 1)'($urandom_range(0, 131071));
				end
				idle_gap();
				push_param(t, predict_point(t));
			end
		end

		drain_pipe();
		repeat (PIPE_LAT + 5) @(posedge clk);

		$display("Swept %0d t values over %0d control point settings, %0d points checked.",
			n_params, n_settings, n_points);
		$display("Included t at 0, one and saturated, all-zero and all-max points, long stall.");
		if (n_mismatch == 0 && pending_pts.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
